// File: rtl/core/ulrm_pkg.sv
// Package with shared types and constants of the UART loopback register model.
package ulrm_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_TICK   = 3'd2,
    MODE_APPEND = 3'd3,
    MODE_DRAIN  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    RESP_OK       = 2'd0,
    RESP_BUS      = 2'd1,
    RESP_DISABLED = 2'd2
  } resp_t;

  localparam logic [2:0] SEL_TXDATA  = 3'd0;
  localparam logic [2:0] SEL_RXDATA  = 3'd1;
  localparam logic [2:0] SEL_STATUS  = 3'd2;
  localparam logic [2:0] SEL_CTRL    = 3'd3;
  localparam logic [2:0] SEL_BAUDDIV = 3'd4;

  localparam int CTRL_ENABLE_BIT = 0;

  localparam logic CFG_LOOP_LATENCY = 1'b0;
  localparam logic CFG_STUCK_FAULT  = 1'b1;

  typedef struct packed {
    logic [31:0] rdata;
    resp_t       resp;
    logic        irq;
    logic        stall;
    logic        last;
    logic        use_mem;
  } res_t;

endpackage

// File: rtl/core/ulrm_rx_mem.sv
// Synchronous RX FIFO storage with one write port and one registered read port.
module ulrm_rx_mem #(
  parameter int FIFO_DEPTH = ulrm_pkg::FIFO_DEPTH_DEF,
  parameter int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [FIFO_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ulrm_ctrl.sv
// Register file, countdown, FIFO pointers and per-item decode of the UART loopback.
module ulrm_ctrl #(
  parameter int FIFO_DEPTH = ulrm_pkg::FIFO_DEPTH_DEF,
  parameter int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  parameter int LVL_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [2:0]         mode,
  input  logic [2:0]         reg_select,
  input  logic [31:0]        write_data,
  input  logic               burst_last,
  input  logic               cfg_wr,
  input  logic               cfg_sel,
  input  logic [31:0]        cfg_wdata,
  output logic [31:0]        cfg_rdata,
  output ulrm_pkg::res_t     res,
  output logic [LVL_W-1:0]   rx_level,
  output logic [LVL_W-1:0]   rec_level,
  output logic               mem_wr_en,
  output logic [ADDR_W-1:0]  mem_wr_addr,
  output logic [7:0]         mem_wr_data,
  output logic               mem_rd_en,
  output logic [ADDR_W-1:0]  mem_rd_addr
);
  import ulrm_pkg::*;

  logic [15:0]       loop_latency_r;
  logic              stuck_fault_r;
  logic [31:0]       ctrl_word_r, ctrl_word_nxt;
  logic [31:0]       baud_r, baud_nxt;
  logic [7:0]        tx_byte_r, tx_byte_nxt;
  logic [7:0]        rx_byte_r, rx_byte_nxt;
  logic [15:0]       busy_r, busy_nxt;
  logic              rx_ready_r, rx_ready_nxt;
  logic [LVL_W-1:0]  rec_count_r, rec_count_nxt;
  logic [ADDR_W-1:0] rx_head_r, rx_head_nxt;
  logic [LVL_W-1:0]  rx_count_r, rx_count_nxt;
  logic              push;
  logic [7:0]        push_data;
  logic              pop;
  logic              wr_ok;
  logic              rd_ok;
  logic [LVL_W:0]    tail_sum;
  logic [LVL_W:0]    tail_pos;

  assign tail_sum = (LVL_W+1)'(rx_head_r) + (LVL_W+1)'(rx_count_r);
  assign tail_pos = (tail_sum >= (LVL_W+1)'(FIFO_DEPTH)) ?
                    tail_sum - (LVL_W+1)'(FIFO_DEPTH) : tail_sum;

  always_comb begin
    ctrl_word_nxt = ctrl_word_r;
    baud_nxt      = baud_r;
    tx_byte_nxt   = tx_byte_r;
    rx_byte_nxt   = rx_byte_r;
    busy_nxt      = busy_r;
    rx_ready_nxt  = rx_ready_r;
    rec_count_nxt = rec_count_r;
    rx_head_nxt   = rx_head_r;
    rx_count_nxt  = rx_count_r;
    push          = 1'b0;
    push_data     = 8'd0;
    pop           = 1'b0;
    wr_ok         = 1'b0;
    rd_ok         = 1'b0;
    res           = '0;
    res.resp      = RESP_OK;
    unique case (mode_t'(mode))
      MODE_READ: begin
        unique case (reg_select)
          SEL_RXDATA: begin
            res.rdata    = {24'd0, rx_byte_r};
            rx_ready_nxt = 1'b0;
          end
          SEL_STATUS: begin
            res.rdata = {29'd0, rx_ready_r, busy_r == 16'd0, busy_r != 16'd0};
          end
          SEL_CTRL:    res.rdata = ctrl_word_r;
          SEL_BAUDDIV: res.rdata = baud_r;
          default:     res.resp  = RESP_BUS;
        endcase
      end
      MODE_WRITE: begin
        unique case (reg_select)
          SEL_TXDATA: begin
            if (!ctrl_word_r[CTRL_ENABLE_BIT]) begin
              res.stall = 1'b1;
              res.resp  = RESP_DISABLED;
            end else begin
              tx_byte_nxt = write_data[7:0];
              busy_nxt    = (loop_latency_r == 16'd0) ? 16'd1 : loop_latency_r;
            end
          end
          SEL_CTRL:    ctrl_word_nxt = write_data;
          SEL_BAUDDIV: baud_nxt      = write_data;
          default:     res.resp      = RESP_BUS;
        endcase
      end
      MODE_TICK: begin
        if (busy_r != 16'd0 && !stuck_fault_r) begin
          busy_nxt = busy_r - 16'd1;
          if (busy_r == 16'd1) begin
            rx_byte_nxt  = tx_byte_r;
            rx_ready_nxt = 1'b1;
            push         = 1'b1;
            push_data    = tx_byte_r;
            res.irq      = 1'b1;
          end
        end
      end
      MODE_APPEND: begin
        push      = 1'b1;
        push_data = write_data[7:0];
        res.last  = burst_last;
      end
      MODE_DRAIN: begin
        pop      = 1'b1;
        res.last = burst_last;
      end
      default: res.resp = RESP_BUS;
    endcase
    if (push) begin
      if (rec_count_r < LVL_W'(FIFO_DEPTH)) begin
        rec_count_nxt = rec_count_r + 1'b1;
      end
      if (rx_count_r < LVL_W'(FIFO_DEPTH)) begin
        wr_ok        = 1'b1;
        rx_count_nxt = rx_count_r + 1'b1;
      end
    end
    if (pop && rx_count_r != '0) begin
      rd_ok        = 1'b1;
      res.use_mem  = 1'b1;
      rx_count_nxt = rx_count_r - 1'b1;
      rx_head_nxt  = (rx_head_r == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_latency_r <= '0;
      stuck_fault_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_sel == CFG_LOOP_LATENCY) begin
        loop_latency_r <= cfg_wdata[15:0];
      end else begin
        stuck_fault_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_word_r <= '0;
      baud_r      <= '0;
      tx_byte_r   <= '0;
      rx_byte_r   <= '0;
      busy_r      <= '0;
      rx_ready_r  <= 1'b0;
      rec_count_r <= '0;
      rx_head_r   <= '0;
      rx_count_r  <= '0;
    end else if (accept) begin
      ctrl_word_r <= ctrl_word_nxt;
      baud_r      <= baud_nxt;
      tx_byte_r   <= tx_byte_nxt;
      rx_byte_r   <= rx_byte_nxt;
      busy_r      <= busy_nxt;
      rx_ready_r  <= rx_ready_nxt;
      rec_count_r <= rec_count_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_count_r  <= rx_count_nxt;
    end
  end

  assign cfg_rdata   = (cfg_sel == CFG_STUCK_FAULT) ? {31'd0, stuck_fault_r}
                                                    : {16'd0, loop_latency_r};
  assign rx_level    = rx_count_nxt;
  assign rec_level   = rec_count_nxt;
  assign mem_wr_en   = accept & wr_ok;
  assign mem_wr_addr = ADDR_W'(tail_pos);
  assign mem_wr_data = push_data;
  assign mem_rd_en   = accept & rd_ok;
  assign mem_rd_addr = rx_head_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= LVL_W'(FIFO_DEPTH))
    else $error("RX FIFO count exceeds depth.");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("One item both pushed and popped the RX FIFO.");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.irq |=> rx_ready_r && busy_r == 16'd0)
    else $error("Loopback did not leave RX valid and the countdown idle.");

endmodule

// File: rtl/core/uart_loopback_register_model.sv
// Top level of the UART loopback register model with item pipeline and output register.
// One item is accepted per clock cycle unless in_stall holds it; its result passes through
// one stage that waits for the RX FIFO memory read and then one output register.
// All register updates of an item are done in the cycle it is accepted; a DMA drain
// reads its byte from the synchronous FIFO memory, whose read port is registered; the
// wait stage covers it. While a result waits at the output, one more item is taken;
// in_stall rises only when both stages are held. The FIFO storage has no reset and
// needs no clearing pass: only bytes that were pushed are ever popped.
module uart_loopback_register_model #(
  parameter int FIFO_DEPTH = ulrm_pkg::FIFO_DEPTH_DEF,
  parameter int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  parameter int LVL_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_mode,
  input  logic [2:0]       in_reg_select,
  input  logic [31:0]      in_write_data,
  input  logic             in_burst_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_resp_code,
  output logic             out_irq_pulse,
  output logic             out_stall_pulse,
  output logic [LVL_W-1:0] out_rx_fifo_level,
  output logic [LVL_W-1:0] out_record_level,
  output logic             out_last_out,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ulrm_pkg::*;

  logic              accept;
  logic              cfg_wr;
  res_t              res;
  logic [LVL_W-1:0]  rx_level;
  logic [LVL_W-1:0]  rec_level;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;
  logic              s1_valid_r;
  res_t              s1_res_r;
  logic [LVL_W-1:0]  s1_rxl_r;
  logic [LVL_W-1:0]  s1_recl_r;
  logic              out_valid_r;
  logic [31:0]       out_rdata_r;
  logic [1:0]        out_resp_r;
  logic              out_irq_r;
  logic              out_stallp_r;
  logic [LVL_W-1:0]  out_rxl_r;
  logic [LVL_W-1:0]  out_recl_r;
  logic              out_last_r;
  logic              out_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign out_load = s1_valid_r & (!out_valid_r | !out_stall);
  assign in_stall = s1_valid_r & !out_load;
  assign accept   = in_valid & !in_stall;

  ulrm_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .ADDR_W    (ADDR_W),
    .LVL_W     (LVL_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_mode),
    .reg_select (in_reg_select),
    .write_data (in_write_data),
    .burst_last (in_burst_last),
    .cfg_wr     (cfg_wr),
    .cfg_sel    (paddr[2]),
    .cfg_wdata  (pwdata),
    .cfg_rdata  (prdata),
    .res        (res),
    .rx_level   (rx_level),
    .rec_level  (rec_level),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr)
  );

  ulrm_rx_mem #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_rx_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r  <= res;
      s1_rxl_r  <= rx_level;
      s1_recl_r <= rec_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rdata_r  <= s1_res_r.use_mem ? {24'd0, mem_rd_data} : s1_res_r.rdata;
      out_resp_r   <= s1_res_r.resp;
      out_irq_r    <= s1_res_r.irq;
      out_stallp_r <= s1_res_r.stall;
      out_rxl_r    <= s1_rxl_r;
      out_recl_r   <= s1_recl_r;
      out_last_r   <= s1_res_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rdata_r;
  assign out_resp_code     = out_resp_r;
  assign out_irq_pulse     = out_irq_r;
  assign out_stall_pulse   = out_stallp_r;
  assign out_rx_fifo_level = out_rxl_r;
  assign out_record_level  = out_recl_r;
  assign out_last_out      = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("Input held while the pipeline had room.");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("Pending item lost while the output was held.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_irq_r |-> out_resp_r == RESP_OK && !out_stallp_r && !out_last_r)
    else $error("Interrupt pulse on a result that is not a plain tick.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stallp_r |-> out_resp_r == RESP_DISABLED)
    else $error("Refused transmit without the disabled response.");

endmodule

// File: tb/uart_loopback_register_model_tb.sv
// Self-checking testbench for the UART loopback register model with a response predictor.
`timescale 1ns / 1ps

module uart_loopback_register_model_tb;
  import ulrm_pkg::*;

  localparam int LVL_W = $clog2(FIFO_DEPTH_DEF + 1);
  localparam int PTR_W = $clog2(FIFO_DEPTH_DEF);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 300;

  localparam logic [31:0] STAT_TX_BUSY  = 32'h1;
  localparam logic [31:0] STAT_TX_EMPTY = 32'h2;
  localparam logic [31:0] STAT_RX_VALID = 32'h4;
  localparam logic [2:0] SEL_BAD_LO  = 3'd5;
  localparam logic [2:0] SEL_BAD_HI  = 3'd7;
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  sel;
    logic [31:0] wdata;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0]      rdata;
    resp_t            resp;
    logic             irq;
    logic             stall;
    logic [LVL_W-1:0] rx_lvl;
    logic [LVL_W-1:0] rec_lvl;
    logic             last;
  } response_t;

  class uart_loop_tracker;
    logic [15:0]      latency;
    logic             fault;
    logic [31:0]      ctrl;
    logic [31:0]      baud;
    logic [7:0]       tx_b;
    logic [7:0]       rx_b;
    logic [15:0]      busy;
    logic             rx_flag;
    logic [LVL_W-1:0] rec_cnt;
    logic [7:0]       rx_mem [FIFO_DEPTH_DEF];
    logic [PTR_W-1:0] rx_rd;
    logic [LVL_W-1:0] rx_cnt;
    response_t        pending_responses[$];
    int errors;
    int checked;
    int loopbacks;
    int refused;
    int drops;

    function new();
      latency = '0;
      fault = 1'b0;
      ctrl = '0;
      baud = '0;
      tx_b = '0;
      rx_b = '0;
      busy = '0;
      rx_flag = 1'b0;
      rec_cnt = '0;
      rx_rd = '0;
      rx_cnt = '0;
      errors = 0;
      checked = 0;
      loopbacks = 0;
      refused = 0;
      drops = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == CFG_LOOP_LATENCY) latency = value[15:0];
      else fault = value[0];
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    function void queue_rx_byte(logic [7:0] b);
      logic [PTR_W-1:0] wr_pos;
      if (rec_cnt < FIFO_DEPTH_DEF) rec_cnt++;
      if (rx_cnt < FIFO_DEPTH_DEF) begin
        wr_pos = rx_rd + rx_cnt[PTR_W-1:0];
        rx_mem[wr_pos] = b;
        rx_cnt++;
      end else begin
        drops++;
      end
    endfunction

    function void predict_response(item_t it);
      response_t r;
      r = '0;
      case (it.mode)
        MODE_READ: begin
          case (it.sel)
            SEL_RXDATA: begin
              r.rdata = {24'd0, rx_b};
              rx_flag = 1'b0;
            end
            SEL_STATUS: begin
              r.rdata = (busy != 0) ? STAT_TX_BUSY : STAT_TX_EMPTY;
              if (rx_flag) r.rdata |= STAT_RX_VALID;
            end
            SEL_CTRL: r.rdata = ctrl;
            SEL_BAUDDIV: r.rdata = baud;
            default: r.resp = RESP_BUS;
          endcase
        end
        MODE_WRITE: begin
          case (it.sel)
            SEL_TXDATA: begin
              if (!ctrl[CTRL_ENABLE_BIT]) begin
                r.stall = 1'b1;
                r.resp = RESP_DISABLED;
                refused++;
              end else begin
                tx_b = it.wdata[7:0];
                busy = (latency != 0) ? latency : 16'd1;
              end
            end
            SEL_CTRL: ctrl = it.wdata;
            SEL_BAUDDIV: baud = it.wdata;
            default: r.resp = RESP_BUS;
          endcase
        end
        MODE_TICK: begin
          if (busy != 0 && !fault) begin
            busy--;
            if (busy == 0) begin
              rx_b = tx_b;
              rx_flag = 1'b1;
              queue_rx_byte(tx_b);
              r.irq = 1'b1;
              loopbacks++;
            end
          end
        end
        MODE_APPEND: begin
          queue_rx_byte(it.wdata[7:0]);
          r.last = it.last;
        end
        MODE_DRAIN: begin
          if (rx_cnt != 0) begin
            r.rdata = {24'd0, rx_mem[rx_rd]};
            rx_rd++;
            rx_cnt--;
          end
          r.last = it.last;
        end
        default: r.resp = RESP_BUS;
      endcase
      r.rx_lvl = rx_cnt;
      r.rec_lvl = rec_cnt;
      pending_responses.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("response %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
    endtask

    task check_response(response_t got);
      response_t want;
      if (pending_responses.size() == 0) begin
        report("response arrived with no item outstanding");
        return;
      end
      want = pending_responses.pop_front();
      checked++;
      compare_field("read_data", got.rdata, want.rdata);
      compare_field("resp_code", 32'(got.resp), 32'(want.resp));
      compare_field("irq_pulse", 32'(got.irq), 32'(want.irq));
      compare_field("stall_pulse", 32'(got.stall), 32'(want.stall));
      compare_field("rx_fifo_level", 32'(got.rx_lvl), 32'(want.rx_lvl));
      compare_field("record_level", 32'(got.rec_lvl), 32'(want.rec_lvl));
      compare_field("last_out", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_mode;
  logic [2:0]       in_reg_select;
  logic [31:0]      in_write_data;
  logic             in_burst_last;
  logic             out_valid;
  logic             out_stall;
  logic [31:0]      out_read_data;
  logic [1:0]       out_resp_code;
  logic             out_irq_pulse;
  logic             out_stall_pulse;
  logic [LVL_W-1:0] out_rx_fifo_level;
  logic [LVL_W-1:0] out_record_level;
  logic             out_last_out;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  uart_loop_tracker sb;
  bit        idle_on;
  int        cycles;
  int        stall_left;
  int        roll;
  int        items_sent;
  response_t observed;

  uart_loopback_register_model DUT (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 12);
      end else if (roll < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed.rdata = out_read_data;
      observed.resp = resp_t'(out_resp_code);
      observed.irq = out_irq_pulse;
      observed.stall = out_stall_pulse;
      observed.rx_lvl = out_rx_fifo_level;
      observed.rec_lvl = out_record_level;
      observed.last = out_last_out;
      sb.check_response(observed);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.", cycles, sb.pending());
      $display("** uart_loopback_register_model: FAILED **");
      $finish;
    end
  end

  function automatic item_t mk(logic [2:0] m, logic [2:0] s, logic [31:0] d, logic l);
    item_t it;
    it.mode = m;
    it.sel = s;
    it.wdata = d;
    it.last = l;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_reg_select <= it.sel;
    in_write_data <= it.wdata;
    in_burst_last <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_response(it);
    items_sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n_items);
    int sent;
    int k;
    int len;
    int ticks;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_item(mk(MODE_APPEND, 3'($urandom_range(0, 7)), $urandom, i == len - 1));
        sent += len;
      end else if (k < 14) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_item(mk(MODE_DRAIN, 3'($urandom_range(0, 7)), $urandom, i == len - 1));
        sent += len;
      end else if (k < 40) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(mk(MODE_WRITE, SEL_CTRL, $urandom | 32'h1, 1'b0));
          sent++;
        end
        send_item(mk(MODE_WRITE, SEL_TXDATA, $urandom, 1'($urandom_range(0, 1))));
        ticks = (sb.latency > 8) ? $urandom_range(0, 8) : $urandom_range(0, sb.latency + 2);
        for (int i = 0; i < ticks; i++) begin
          send_item(mk(MODE_TICK, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
          if ($urandom_range(0, 4) == 0)
            send_item(mk(MODE_READ, SEL_STATUS, $urandom, 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 1) == 0)
          send_item(mk(MODE_READ, SEL_RXDATA, $urandom, 1'($urandom_range(0, 1))));
        sent += ticks + 2;
      end else if (k < 46) begin
        send_item(mk(MODE_WRITE, SEL_CTRL,
                     ($urandom_range(0, 4) == 0) ? ($urandom & 32'hFFFF_FFFE) : $urandom,
                     1'($urandom_range(0, 1))));
        sent++;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 30)
          send_item(mk(MODE_READ, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
        else if (k < 50)
          send_item(mk(MODE_WRITE, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
        else if (k < 75)
          send_item(mk(MODE_TICK, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
        else if (k < 83)
          send_item(mk(MODE_APPEND, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
        else if (k < 91)
          send_item(mk(MODE_DRAIN, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1))));
        else
          send_item(mk(3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)),
                       3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  int phase_lat [N_PHASES];
  int phase_fault [N_PHASES];
  int phase_idle [N_PHASES];

  initial begin
    sb = new();
    phase_lat = '{1, 0, 3, 65535, 2, 7};
    phase_fault = '{0, 0, 0, 0, 1, 0};
    phase_idle = '{0, 1, 1, 1, 1, 0};
    cycles = 0;
    items_sent = 0;
    idle_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_reg_select = '0;
    in_write_data = '0;
    in_burst_last = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_item(mk(MODE_READ, SEL_TXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_RXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_STATUS, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_BAD_LO, 32'h0, 1'b1));
    send_item(mk(MODE_WRITE, SEL_TXDATA, 32'hFFFF_FFFF, 1'b1));
    send_item(mk(MODE_WRITE, SEL_RXDATA, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(MODE_WRITE, SEL_STATUS, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(MODE_WRITE, SEL_BAD_HI, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(MODE_WRITE, SEL_BAUDDIV, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(MODE_READ, SEL_BAUDDIV, 32'h0, 1'b0));
    send_item(mk(MODE_WRITE, SEL_CTRL, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(MODE_READ, SEL_CTRL, 32'h0, 1'b0));
    send_item(mk(MODE_DRAIN, SEL_TXDATA, 32'h0, 1'b1));
    send_item(mk(MODE_WRITE, SEL_TXDATA, 32'h0000_00A5, 1'b0));
    send_item(mk(MODE_READ, SEL_STATUS, 32'h0, 1'b0));
    send_item(mk(MODE_WRITE, SEL_TXDATA, 32'hFFFF_FF5A, 1'b0));
    send_item(mk(MODE_TICK, SEL_TXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_TICK, SEL_TXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_STATUS, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_RXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_READ, SEL_STATUS, 32'h0, 1'b0));
    send_item(mk(MODE_APPEND, SEL_TXDATA, 32'hFFFF_FFFF, 1'b1));
    send_item(mk(MODE_DRAIN, SEL_TXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_BAD_LO, SEL_TXDATA, 32'h0, 1'b0));
    send_item(mk(MODE_BAD_HI, SEL_BAD_HI, 32'hFFFF_FFFF, 1'b1));
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_LOOP_LATENCY, {16'($urandom), 16'(phase_lat[p])});
      write_reg(CFG_STUCK_FAULT, ($urandom & 32'hFFFF_FFFE) | 32'(phase_fault[p]));
      idle_on = phase_idle[p][0];
      run_phase(PHASE_ITEMS);
      settle();
    end

    $display("Summary: %0d items sent, %0d responses checked over %0d register settings.",
             items_sent, sb.checked, N_PHASES);
    $display("Summary: %0d loopbacks, %0d refused TX writes, %0d bytes dropped at a full FIFO.",
             sb.loopbacks, sb.refused, sb.drops);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** uart_loopback_register_model: PASSED **");
    else
      $display("** uart_loopback_register_model: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ulrm_pkg.sv
rtl/core/ulrm_rx_mem.sv
rtl/core/ulrm_ctrl.sv
rtl/core/uart_loopback_register_model.sv
tb/uart_loopback_register_model_tb.sv
